// ===== rtl/frc_pkg.sv =====
`default_nettype none

package frc_pkg;

    localparam int unsigned DW          = 32;
    localparam int unsigned UNIT_W      = 16;
    localparam int unsigned RW          = 48;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_REGIONS = 4;
    localparam int unsigned REGIONS_DEF = 4;
    localparam int unsigned FIFO_DEPTH  = 2;

    localparam logic [DW-1:0]     CAPACITY_RST    = 32'd1048576;
    localparam logic [UNIT_W-1:0] WRITE_UNIT_RST  = 16'd1;
    localparam logic [DW-1:0]     SECTOR_SIZE_RST = 32'd4096;

    typedef enum logic [1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_ERASE = 2'd2,
        ACT_BAD   = 2'd3
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY    = 3'd0,
        CFG_WRITE_UNIT  = 3'd1,
        CFG_SECTOR_SIZE = 3'd2,
        CFG_REGION_0    = 3'd3,
        CFG_REGION_1    = 3'd4,
        CFG_REGION_2    = 3'd5,
        CFG_REGION_3    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        action_t       action;
        logic [DW-1:0] address;
        logic [DW-1:0] length;
    } request_t;

    typedef struct packed {
        logic status;
        logic is_empty;
    } result_t;

    typedef struct packed {
        logic          pend;
        logic          chk;
        logic [DW-1:0] n;
        logic [DW-1:0] d;
    } job_t;

    typedef struct packed {
        logic base_ok;
        logic is_empty;
        job_t a;
        job_t b;
    } item_t;

    typedef struct packed {
        logic base_ok;
        logic is_empty;
        logic chk_a;
        logic chk_b;
    } tag_t;

endpackage

`default_nettype wire

// ===== rtl/flash_request_range_checker.sv =====
// Flash request range checker. Takes one read, write or erase request per
// cycle while full is low and answers each with one status beat, in order.
// A request enters the front stages (range check, write alignment or erase
// boundary setup, then one stage per sector region that locates the region
// holding each erase end), crosses a two-beat queue, and runs through a
// 32-stage remainder pipeline that checks alignment one dividend bit per
// stage. Throughput is one request per cycle, limited only by pop on the
// result side. Configuration writes take effect at once; region offsets are
// rebuilt from the region words through a product and an end register per
// region, which the front stages cover, so a request may follow a write in
// the next cycle.
`default_nettype none

module flash_request_range_checker #(
    parameter int unsigned REGIONS = frc_pkg::REGIONS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [frc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [frc_pkg::RW-1:0]        cfg_data,
    input  wire logic                          push,
    output logic                               full,
    input  wire frc_pkg::request_t             request,
    output logic                               empty,
    input  wire logic                          pop,
    output frc_pkg::result_t                   result
);

    localparam int unsigned EW = frc_pkg::RW + $clog2(REGIONS);
    localparam int unsigned IW = $bits(frc_pkg::item_t);
    localparam int unsigned OW = $bits(frc_pkg::result_t);

    logic [frc_pkg::DW-1:0]              capacity;
    logic [frc_pkg::UNIT_W-1:0]          unit;
    logic [frc_pkg::DW-1:0]              sector_size;
    logic [REGIONS-1:0][frc_pkg::DW-1:0] region_size;
    logic [REGIONS-1:0][EW-1:0]          region_end;
    logic [REGIONS-1:0]                  region_used;

    logic            mid_push;
    frc_pkg::item_t  mid_item;
    logic            mid_full;
    logic            mid_pop;
    logic            mid_empty;
    logic [IW-1:0]   mid_dout;
    logic            out_push;
    frc_pkg::result_t out_res;
    logic            out_full;
    logic [OW-1:0]   out_dout;

    frc_geom #(.REGIONS(REGIONS)) u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .capacity    (capacity),
        .unit        (unit),
        .sector_size (sector_size),
        .region_size (region_size),
        .region_end  (region_end),
        .region_used (region_used)
    );

    frc_front #(.REGIONS(REGIONS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .request     (request),
        .capacity    (capacity),
        .unit        (unit),
        .sector_size (sector_size),
        .region_size (region_size),
        .region_end  (region_end),
        .region_used (region_used),
        .mid_push    (mid_push),
        .mid_item    (mid_item),
        .mid_full    (mid_full)
    );

    frc_fifo #(.W(IW), .DEPTH(frc_pkg::FIFO_DEPTH)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_item),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    frc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_item  (frc_pkg::item_t'(mid_dout)),
        .mid_pop   (mid_pop),
        .out_push  (out_push),
        .out_res   (out_res),
        .out_full  (out_full)
    );

    frc_fifo #(.W(OW), .DEPTH(frc_pkg::FIFO_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (out_res),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty)
    );

    assign result = frc_pkg::result_t'(out_dout);

endmodule

`default_nettype wire

// ===== rtl/frc_fifo.sv =====
`default_nettype none

module frc_fifo #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = frc_pkg::FIFO_DEPTH
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] din,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      dout,
    output logic              empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frc_geom.sv =====
`default_nettype none

module frc_geom #(
    parameter int unsigned REGIONS = frc_pkg::REGIONS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [frc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [frc_pkg::RW-1:0]               cfg_data,
    output logic [frc_pkg::DW-1:0]                    capacity,
    output logic [frc_pkg::UNIT_W-1:0]                unit,
    output logic [frc_pkg::DW-1:0]                    sector_size,
    output logic [REGIONS-1:0][frc_pkg::DW-1:0]       region_size,
    output logic [REGIONS-1:0][frc_pkg::RW+$clog2(REGIONS)-1:0] region_end,
    output logic [REGIONS-1:0]                        region_used
);

    localparam int unsigned DW = frc_pkg::DW;
    localparam int unsigned RW = frc_pkg::RW;
    localparam int unsigned EW = RW + $clog2(REGIONS);

    logic [DW-1:0]                 cap_reg;
    logic [frc_pkg::UNIT_W-1:0]    unit_reg;
    logic [DW-1:0]                 ssz_reg;
    logic [RW-1:0]                 region_reg [frc_pkg::CFG_REGIONS];

    logic [REGIONS-1:0][RW-1:0]    prod_reg;
    logic [REGIONS-1:0][EW-1:0]    end_reg;
    logic [REGIONS-1:0]            used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= frc_pkg::CAPACITY_RST;
            unit_reg   <= frc_pkg::WRITE_UNIT_RST;
            ssz_reg    <= frc_pkg::SECTOR_SIZE_RST;
            region_reg <= '{default: '0};
        end
        else if (cfg_we)
        begin
            case (frc_pkg::cfg_idx_t'(cfg_index))
                frc_pkg::CFG_CAPACITY:    cap_reg       <= cfg_data[DW-1:0];
                frc_pkg::CFG_WRITE_UNIT:  unit_reg      <= cfg_data[frc_pkg::UNIT_W-1:0];
                frc_pkg::CFG_SECTOR_SIZE: ssz_reg       <= cfg_data[DW-1:0];
                frc_pkg::CFG_REGION_0:    region_reg[0] <= cfg_data;
                frc_pkg::CFG_REGION_1:    region_reg[1] <= cfg_data;
                frc_pkg::CFG_REGION_2:    region_reg[2] <= cfg_data;
                frc_pkg::CFG_REGION_3:    region_reg[3] <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // region ends are rebuilt after a write, one region per cycle
    for (genvar k = 0; k < REGIONS; k++)
    begin : g_region
        logic [RW-1:0]              word;
        logic [DW-1:0]              sz;
        logic [frc_pkg::CNT_W-1:0]  cnt;
        logic [EW-1:0]              base;
        logic                       walk_on;

        if (k < frc_pkg::CFG_REGIONS)
        begin : g_word
            assign word = region_reg[k];
        end
        else
        begin : g_none
            assign word = '0;
        end

        assign sz  = word[DW-1:0];
        assign cnt = word[DW +: frc_pkg::CNT_W];

        if (k == 0)
        begin : g_first
            assign base    = '0;
            assign walk_on = 1'b1;
        end
        else
        begin : g_next
            assign base    = end_reg[k-1];
            assign walk_on = used_reg[k-1] && (end_reg[k-1] < EW'(cap_reg));
        end

        assign region_size[k] = sz;

        always_ff @(posedge clk)
        begin
            prod_reg[k] <= sz * cnt;
            end_reg[k]  <= base + EW'(prod_reg[k]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                used_reg[k] <= 1'b0;
            end
            else
            begin
                used_reg[k] <= walk_on && (cnt != '0);
            end
        end
    end

    assign capacity    = cap_reg;
    assign unit        = (unit_reg == '0) ? frc_pkg::UNIT_W'(1) : unit_reg;
    assign sector_size = ssz_reg;
    assign region_end  = end_reg;
    assign region_used = used_reg;

endmodule

`default_nettype wire

// ===== rtl/frc_front.sv =====
`default_nettype none

module frc_front #(
    parameter int unsigned REGIONS = frc_pkg::REGIONS_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     push,
    output logic                                          full,
    input  wire frc_pkg::request_t                        request,
    input  wire logic [frc_pkg::DW-1:0]                   capacity,
    input  wire logic [frc_pkg::UNIT_W-1:0]               unit,
    input  wire logic [frc_pkg::DW-1:0]                   sector_size,
    input  wire logic [REGIONS-1:0][frc_pkg::DW-1:0]      region_size,
    input  wire logic [REGIONS-1:0][frc_pkg::RW+$clog2(REGIONS)-1:0] region_end,
    input  wire logic [REGIONS-1:0]                       region_used,
    output logic                                          mid_push,
    output frc_pkg::item_t                                mid_item,
    input  wire logic                                     mid_full
);

    localparam int unsigned DW = frc_pkg::DW;
    localparam int unsigned EW = frc_pkg::RW + $clog2(REGIONS);
    localparam int unsigned FS = REGIONS + 3;

    frc_pkg::item_t st_reg [FS];
    frc_pkg::item_t st_in  [FS];
    logic [FS-1:0]  vld_reg;
    logic           f_en;
    logic           accept;

    function automatic frc_pkg::job_t erase_job(
        input logic [DW-1:0] off,
        input logic [DW-1:0] cap,
        input logic [DW-1:0] ssz
    );
        frc_pkg::job_t j;
        j   = '0;
        j.n = off;
        j.d = DW'(1);
        if (off < cap)
        begin
            if (ssz != '0)
            begin
                j.chk = 1'b1;
                j.d   = ssz;
            end
            else
            begin
                j.pend = 1'b1;
            end
        end
        return j;
    endfunction

    function automatic frc_pkg::job_t walk_job(
        input frc_pkg::job_t j,
        input logic          used,
        input logic [EW-1:0] base,
        input logic [EW-1:0] lim,
        input logic [DW-1:0] sz
    );
        frc_pkg::job_t r;
        r = j;
        if (j.pend && used && (EW'(j.n) < lim))
        begin
            r.pend = 1'b0;
            r.chk  = 1'b1;
            r.n    = j.n - base[DW-1:0];
            r.d    = sz;
        end
        return r;
    endfunction

    assign f_en   = !vld_reg[FS-1] || !mid_full;
    assign full   = !f_en;
    assign accept = push && f_en;

    // classify
    always_comb
    begin
        logic          empty_len;
        logic          range_ok;
        logic [DW-1:0] end_off;
        frc_pkg::item_t c;
        empty_len  = (request.length == '0);
        end_off    = request.address + request.length;
        range_ok   = (request.address <= capacity)
                  && (request.length <= capacity - request.address);
        c          = '0;
        c.is_empty = empty_len;
        c.base_ok  = empty_len || (range_ok && (request.action != frc_pkg::ACT_BAD));
        c.a.n      = request.address;
        c.a.d      = DW'(1);
        c.b.n      = end_off;
        c.b.d      = DW'(1);
        if (!empty_len && range_ok)
        begin
            case (request.action)
                frc_pkg::ACT_WRITE:
                begin
                    c.a.chk = 1'b1;
                    c.a.d   = DW'(unit);
                    c.b.chk = 1'b1;
                    c.b.n   = request.length;
                    c.b.d   = DW'(unit);
                end
                frc_pkg::ACT_ERASE:
                begin
                    c.a = erase_job(request.address, capacity, sector_size);
                    c.b = erase_job(end_off, capacity, sector_size);
                end
                default:
                begin
                end
            endcase
        end
        st_in[0] = c;
    end

    // region walk, one region per stage
    for (genvar s = 0; s < FS - 1; s++)
    begin : g_stage
        if (s >= 2)
        begin : g_walk
            logic [EW-1:0] base;
            if (s == 2)
            begin : g_b0
                assign base = '0;
            end
            else
            begin : g_bn
                assign base = region_end[s-3];
            end
            always_comb
            begin
                st_in[s+1]   = st_reg[s];
                st_in[s+1].a = walk_job(st_reg[s].a, region_used[s-2], base,
                                        region_end[s-2], region_size[s-2]);
                st_in[s+1].b = walk_job(st_reg[s].b, region_used[s-2], base,
                                        region_end[s-2], region_size[s-2]);
            end
        end
        else
        begin : g_copy
            assign st_in[s+1] = st_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (f_en)
        begin
            vld_reg <= {vld_reg[FS-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            for (int i = 0; i < FS; i++)
            begin
                st_reg[i] <= st_in[i];
            end
        end
    end

    // uncovered address is no boundary
    always_comb
    begin
        mid_item = st_reg[FS-1];
        if (st_reg[FS-1].a.pend || st_reg[FS-1].b.pend)
        begin
            mid_item.base_ok = 1'b0;
        end
        mid_item.a.pend = 1'b0;
        mid_item.b.pend = 1'b0;
    end

    assign mid_push = vld_reg[FS-1] && !mid_full;

endmodule

`default_nettype wire

// ===== rtl/frc_rem.sv =====
`default_nettype none

module frc_rem (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic [frc_pkg::DW-1:0]  n,
    input  wire logic [frc_pkg::DW-1:0]  d,
    output logic [frc_pkg::DW-1:0]       rem
);

    localparam int unsigned DW = frc_pkg::DW;

    logic [DW-1:0] r_reg [DW];
    logic [DW-1:0] n_reg [DW-1];
    logic [DW-1:0] d_reg [DW-1];

    // restoring remainder, one dividend bit per stage
    for (genvar s = 0; s < DW; s++)
    begin : g_stage
        logic [DW-1:0] r_prev;
        logic [DW-1:0] n_prev;
        logic [DW-1:0] d_prev;
        logic [DW:0]   t;
        logic [DW:0]   diff;

        if (s == 0)
        begin : g_first
            assign r_prev = '0;
            assign n_prev = n;
            assign d_prev = d;
        end
        else
        begin : g_next
            assign r_prev = r_reg[s-1];
            assign n_prev = n_reg[s-1];
            assign d_prev = d_reg[s-1];
        end

        assign t    = {r_prev, n_prev[DW-1-s]};
        assign diff = t - {1'b0, d_prev};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s] <= (t >= {1'b0, d_prev}) ? diff[DW-1:0] : t[DW-1:0];
            end
        end

        if (s < DW - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[s] <= n_prev;
                    d_reg[s] <= d_prev;
                end
            end
        end
    end

    assign rem = r_reg[DW-1];

endmodule

`default_nettype wire

// ===== rtl/frc_back.sv =====
`default_nettype none

module frc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             mid_empty,
    input  wire frc_pkg::item_t   mid_item,
    output logic                  mid_pop,
    output logic                  out_push,
    output frc_pkg::result_t      out_res,
    input  wire logic             out_full
);

    localparam int unsigned DW = frc_pkg::DW;

    logic [DW-1:0]   bv_reg;
    frc_pkg::tag_t   tag_reg [DW];
    frc_pkg::tag_t   tag_in;
    logic            b_en;
    logic [DW-1:0]   rem_a;
    logic [DW-1:0]   rem_b;
    frc_pkg::tag_t   tl;

    assign b_en    = !(bv_reg[DW-1] && out_full);
    assign mid_pop = b_en && !mid_empty;

    assign tag_in.base_ok  = mid_item.base_ok;
    assign tag_in.is_empty = mid_item.is_empty;
    assign tag_in.chk_a    = mid_item.a.chk;
    assign tag_in.chk_b    = mid_item.b.chk;

    frc_rem u_rem_a (
        .clk (clk),
        .en  (b_en),
        .n   (mid_item.a.n),
        .d   (mid_item.a.d),
        .rem (rem_a)
    );

    frc_rem u_rem_b (
        .clk (clk),
        .en  (b_en),
        .n   (mid_item.b.n),
        .d   (mid_item.b.d),
        .rem (rem_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
        end
        else if (b_en)
        begin
            bv_reg <= {bv_reg[DW-2:0], mid_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < DW; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign tl                = tag_reg[DW-1];
    assign out_push          = bv_reg[DW-1] && !out_full;
    assign out_res.is_empty  = tl.is_empty;
    assign out_res.status    = !(tl.base_ok
                                 && (!tl.chk_a || (rem_a == '0))
                                 && (!tl.chk_b || (rem_b == '0)));

endmodule

`default_nettype wire
